[design/tracked_position_interpolator_macros.svh]
// Assertion helpers for the tracked position interpolator.
`ifndef TRACKED_POSITION_INTERPOLATOR_MACROS_SVH
`define TRACKED_POSITION_INTERPOLATOR_MACROS_SVH

// Checked only out of reset.
`define TPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define TPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/tpi_pkg.sv]
`timescale 1ns / 1ps
package tpi_pkg;

  localparam logic [16:0] ALPHA_ONE      = 17'd65536;
  localparam logic [30:0] TELEPORT_RESET = 31'd3145728;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_SKIP     = 2'd1;
  localparam logic [1:0] REG_TELEPORT = 2'd2;

  localparam logic OP_FRAME  = 1'b0;
  localparam logic OP_OBJECT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_UPDATE,
    ST_MUL,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] seen;
    logic [31:0] last_x;
    logic [31:0] last_y;
    logic [31:0] last_z;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic [31:0] prev_z;
  } row_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] skip_mask;
    logic [30:0] teleport_limit;
  } cfg_t;

endpackage

[design/tpi_if.sv]
`timescale 1ns / 1ps
interface tpi_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        capture;
  logic [16:0] alpha;
  logic [31:0] entity_key;
  logic [31:0] entity_flags;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, op, capture, alpha, entity_key, entity_flags,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, op, capture, alpha, entity_key, entity_flags,
                pos_x, pos_y, pos_z, output ready);
endinterface

interface tpi_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] placed_key;
  logic [31:0] placed_flags;
  logic signed [31:0] draw_x;
  logic signed [31:0] draw_y;
  logic signed [31:0] draw_z;

  modport source (output valid, placed_key, placed_flags, draw_x, draw_y, draw_z,
                  input ready);
  modport sink (input valid, placed_key, placed_flags, draw_x, draw_y, draw_z,
                output ready);
endinterface

[design/tpi_regs.sv]
`timescale 1ns / 1ps
module tpi_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tpi_pkg::cfg_t      cfg_o
);

  tpi_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        tpi_pkg::REG_ENABLE:   cfg_d.enable         = pwdata[0];
        tpi_pkg::REG_SKIP:     cfg_d.skip_mask      = pwdata;
        tpi_pkg::REG_TELEPORT: cfg_d.teleport_limit = pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b1;
      cfg_q.skip_mask      <= '0;
      cfg_q.teleport_limit <= tpi_pkg::TELEPORT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      tpi_pkg::REG_ENABLE:   prdata = {31'd0, cfg_q.enable};
      tpi_pkg::REG_SKIP:     prdata = cfg_q.skip_mask;
      tpi_pkg::REG_TELEPORT: prdata = {1'b0, cfg_q.teleport_limit};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/tracked_position_interpolator.sv]
`timescale 1ns / 1ps
// A frame-start request is taken in idle. An object request reads and checks
// probed slots one at a time, up to PROBE_LIMIT of them, then updates the row
// and blends each axis through one shared multiplier. One request at a time.
// Throughput is set by the probe loop over the slot memory's single read port.
// Reset: after rst_ni rises all TABLE_DEPTH slots of the table are cleared, no
// requests taken meanwhile; config registers are writable throughout.
module tracked_position_interpolator #(
  parameter int TABLE_DEPTH = 2048,
  parameter int PROBE_LIMIT = 64,
  parameter int HASH_SHIFT  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpi_req_if.sink     req_i,
  tpi_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "tracked_position_interpolator_macros.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam logic [PW-1:0] PROBE_LAST = PW'(PROBE_LIMIT - 1);
  localparam logic [AW-1:0] ADDR_LAST  = AW'(TABLE_DEPTH - 1);

  tpi_pkg::cfg_t   cfg;
  tpi_pkg::state_e state_q, state_d;

  tpi_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // slot memory
  tpi_pkg::row_t mem [TABLE_DEPTH];
  tpi_pkg::row_t rd_row_q, mem_wd, new_row;
  logic [AW-1:0] mem_wa, rd_addr;
  logic          mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_row_q <= mem[rd_addr];
  end

  // control and frame state
  logic [AW-1:0] clr_q;
  logic [PW-1:0] probe_q;
  logic [1:0]    k_q;
  logic          hit_q, found_q, out_valid_q;
  logic [31:0]   frame_cnt_q;
  logic          frame_cap_q;
  logic [16:0]   frame_alpha_q;

  // item and datapath registers
  logic [31:0]        key_q, flags_q;
  logic [31:0]        pos_q [3];
  logic [AW-1:0]      hash_q, idx_q;
  tpi_pkg::row_t      cur_q;
  logic signed [32:0] delta_q [3];
  logic [31:0]        last_q [3];
  logic [31:0]        draw_q [3];
  logic signed [50:0] prod_q;
  logic [31:0]        out_key_q, out_flags_q, out_x_q, out_y_q, out_z_q;

  logic [31:0]   hash_full;
  logic [AW-1:0] slot;
  logic          acc, skip, key_hit, reclaim, sel_now, write_row, out_free;
  logic [16:0]   inv;

  assign acc       = req_i.valid & req_i.ready;
  assign skip      = !cfg.enable || (req_i.entity_key == '0)
                     || ((req_i.entity_flags & cfg.skip_mask) != '0);
  assign hash_full = req_i.entity_key >> HASH_SHIFT;
  assign slot      = hash_q + AW'(probe_q);
  assign key_hit   = (rd_row_q.key == key_q);
  assign reclaim   = (rd_row_q.key == '0) || ((rd_row_q.seen + 32'd2) < frame_cnt_q);
  assign sel_now   = key_hit || (!found_q && reclaim);
  assign write_row = frame_cap_q || !hit_q;
  assign out_free  = !out_valid_q || res_o.ready;
  assign inv       = tpi_pkg::ALPHA_ONE - frame_alpha_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpi_pkg::ST_CLEAR: if (clr_q == ADDR_LAST) state_d = tpi_pkg::ST_IDLE;
      tpi_pkg::ST_IDLE: begin
        if (acc && req_i.op == tpi_pkg::OP_OBJECT && !skip) state_d = tpi_pkg::ST_READ;
      end
      tpi_pkg::ST_READ: state_d = tpi_pkg::ST_CHECK;
      tpi_pkg::ST_CHECK: begin
        if (key_hit) state_d = tpi_pkg::ST_UPDATE;
        else if (probe_q != PROBE_LAST) state_d = tpi_pkg::ST_READ;
        else if (found_q || reclaim) state_d = tpi_pkg::ST_UPDATE;
        else state_d = tpi_pkg::ST_IDLE;
      end
      tpi_pkg::ST_UPDATE: state_d = tpi_pkg::ST_MUL;
      tpi_pkg::ST_MUL:    state_d = tpi_pkg::ST_ROUND;
      tpi_pkg::ST_ROUND:  state_d = (k_q == 2'd2) ? tpi_pkg::ST_DONE : tpi_pkg::ST_MUL;
      tpi_pkg::ST_DONE:   if (out_free) state_d = tpi_pkg::ST_IDLE;
      default:            state_d = tpi_pkg::ST_IDLE;
    endcase
  end

  // state outputs: memory port and handshake
  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = new_row;
    rd_addr     = slot;
    case (state_q)
      tpi_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      tpi_pkg::ST_IDLE:   req_i.ready = 1'b1;
      tpi_pkg::ST_UPDATE: mem_we = write_row;
      default: ;
    endcase
  end

  // row after the update rules
  always_comb begin
    new_row = cur_q;
    if (write_row) begin
      if (frame_cap_q && hit_q && cur_q.seen == (frame_cnt_q - 32'd1)) begin
        new_row.prev_x = cur_q.last_x;
        new_row.prev_y = cur_q.last_y;
        new_row.prev_z = cur_q.last_z;
      end else begin
        new_row.prev_x = pos_q[0];
        new_row.prev_y = pos_q[1];
        new_row.prev_z = pos_q[2];
      end
      new_row.last_x = pos_q[0];
      new_row.last_y = pos_q[1];
      new_row.last_z = pos_q[2];
      new_row.key    = key_q;
      new_row.seen   = frame_cnt_q;
    end
  end

  // deltas and teleport test
  logic signed [32:0] dx, dy, dz;
  logic [33:0]        ax, ay;
  logic               tele;

  assign dx   = $signed({new_row.last_x[31], new_row.last_x})
                - $signed({new_row.prev_x[31], new_row.prev_x});
  assign dy   = $signed({new_row.last_y[31], new_row.last_y})
                - $signed({new_row.prev_y[31], new_row.prev_y});
  assign dz   = $signed({new_row.last_z[31], new_row.last_z})
                - $signed({new_row.prev_z[31], new_row.prev_z});
  assign ax   = dx[32] ? (34'd0 - {dx[32], dx}) : {1'b0, dx};
  assign ay   = dy[32] ? (34'd0 - {dy[32], dy}) : {1'b0, dy};
  assign tele = (ax > {3'd0, cfg.teleport_limit}) || (ay > {3'd0, cfg.teleport_limit});

  // rounding, ties away from zero, then subtract from last
  logic        neg;
  logic [50:0] mag, qm;
  logic [31:0] qs;

  assign neg = prod_q[50];
  assign mag = neg ? (51'd0 - prod_q) : prod_q;
  assign qm  = (mag + 51'd32768) >> 16;
  assign qs  = neg ? (32'd0 - qm[31:0]) : qm[31:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tpi_pkg::ST_CLEAR;
      clr_q         <= '0;
      probe_q       <= '0;
      k_q           <= '0;
      hit_q         <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      frame_cnt_q   <= '0;
      frame_cap_q   <= 1'b0;
      frame_alpha_q <= tpi_pkg::ALPHA_ONE;
    end else begin
      state_q <= state_d;
      if (state_q == tpi_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      // result register: load from done, else drain on ready
      if (state_q == tpi_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        tpi_pkg::ST_IDLE: begin
          probe_q <= '0;
          k_q     <= '0;
          hit_q   <= 1'b0;
          found_q <= 1'b0;
          if (acc && req_i.op == tpi_pkg::OP_FRAME) begin
            frame_cap_q   <= req_i.capture;
            frame_alpha_q <= (req_i.alpha > tpi_pkg::ALPHA_ONE) ? tpi_pkg::ALPHA_ONE
                                                                : req_i.alpha;
            if (req_i.capture) frame_cnt_q <= frame_cnt_q + 32'd1;
          end
        end
        tpi_pkg::ST_CHECK: begin
          probe_q <= probe_q + PW'(1);
          if (key_hit) hit_q <= 1'b1;
          if (sel_now) found_q <= 1'b1;
        end
        tpi_pkg::ST_ROUND: k_q <= k_q + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == tpi_pkg::ST_IDLE && acc) begin
      key_q    <= req_i.entity_key;
      flags_q  <= req_i.entity_flags;
      pos_q[0] <= req_i.pos_x;
      pos_q[1] <= req_i.pos_y;
      pos_q[2] <= req_i.pos_z;
      hash_q   <= hash_full[AW-1:0];
    end
    if (state_q == tpi_pkg::ST_CHECK && sel_now) begin
      cur_q <= rd_row_q;
      idx_q <= slot;
    end
    if (state_q == tpi_pkg::ST_UPDATE) begin
      delta_q[0] <= tele ? 33'sd0 : dx;
      delta_q[1] <= tele ? 33'sd0 : dy;
      delta_q[2] <= tele ? 33'sd0 : dz;
      last_q[0]  <= new_row.last_x;
      last_q[1]  <= new_row.last_y;
      last_q[2]  <= new_row.last_z;
    end
    if (state_q == tpi_pkg::ST_MUL) begin
      prod_q <= 51'(delta_q[k_q] * $signed({1'b0, inv}));
    end
    if (state_q == tpi_pkg::ST_ROUND) begin
      draw_q[k_q] <= last_q[k_q] - qs;
    end
    if (state_q == tpi_pkg::ST_DONE && out_free) begin
      out_key_q   <= key_q;
      out_flags_q <= flags_q;
      out_x_q     <= draw_q[0];
      out_y_q     <= draw_q[1];
      out_z_q     <= draw_q[2];
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.placed_key   = out_key_q;
  assign res_o.placed_flags = out_flags_q;
  assign res_o.draw_x       = out_x_q;
  assign res_o.draw_y       = out_y_q;
  assign res_o.draw_z       = out_z_q;

  `TPI_ASSERT(a_res_from_done, $rose(out_valid_q) |-> $past(state_q == tpi_pkg::ST_DONE), "result raised outside done state")
  `TPI_ASSERT(a_hit_is_found, hit_q |-> found_q, "hit recorded without a selected slot")
  `TPI_ASSERT(a_update_found, state_q == tpi_pkg::ST_UPDATE |-> found_q, "update without a selected slot")
  `TPI_ASSERT(a_no_req_busy, state_q != tpi_pkg::ST_IDLE |-> !req_i.ready, "request taken while busy")
  `TPI_ASSERT_ALWAYS(a_clear_no_req, state_q == tpi_pkg::ST_CLEAR |-> !req_i.ready, "request taken during clear")

endmodule
